>>> rtl/gpsm_pkg.sv
// Shared types and constants of the gamepad poll serial master.
`timescale 1ns / 1ps
`default_nettype none
package gpsm_pkg;

  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_LIGHT = 2'd1;
  localparam logic [1:0] CMD_SCAN  = 2'd2;

  localparam logic [1:0] REG_HALF_PERIOD = 2'd0;
  localparam logic [1:0] REG_RED_ID      = 2'd1;
  localparam logic [1:0] REG_GREEN_ID    = 2'd2;

  localparam logic [1:0] MODE_NONE  = 2'd0;
  localparam logic [1:0] MODE_RED   = 2'd1;
  localparam logic [1:0] MODE_GREEN = 2'd2;

  localparam logic [7:0] BYTE_START = 8'h01;
  localparam logic [7:0] BYTE_POLL  = 8'h42;
  localparam logic [7:0] MARK_KEYS  = 8'h5A;

  localparam int CFG_WIDTH = 10;

  typedef struct packed {
    logic [9:0] half_period;
    logic [7:0] red_mode_id;
    logic [7:0] green_mode_id;
  } cfg_t;

  typedef struct packed {
    logic        select_n;
    logic        serial_clock;
    logic        data_out;
    logic        busy_res;
    logic        done_res;
    logic [1:0]  link_mode;
    logic        keys_valid;
    logic [15:0] buttons;
    logic [7:0]  left_x;
    logic [7:0]  left_y;
    logic [7:0]  right_x;
    logic [7:0]  right_y;
  } result_t;

  function automatic logic [7:0] tx_byte(input logic [3:0] idx);
    logic [7:0] b;
    b = 8'h00;
    if (idx == 4'd0) begin
      b = BYTE_START;
    end else if (idx == 4'd1) begin
      b = BYTE_POLL;
    end
    return b;
  endfunction

endpackage
`default_nettype wire

>>> rtl/gpsm_in_if.sv
// Input channel: one tick word with command and sampled data level.
`timescale 1ns / 1ps
`default_nettype none
interface gpsm_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic       data_in;

  modport source (output valid, output cmd, output data_in, input ready);
  modport sink (input valid, input cmd, input data_in, output ready);
endinterface
`default_nettype wire

>>> rtl/gpsm_out_if.sv
// Output channel: line levels and held decode results after each tick.
`timescale 1ns / 1ps
`default_nettype none
interface gpsm_out_if;
  logic        valid;
  logic        ready;
  logic        select_n;
  logic        serial_clock;
  logic        data_out;
  logic        busy_res;
  logic        done_res;
  logic [1:0]  link_mode;
  logic        keys_valid;
  logic [15:0] buttons;
  logic [7:0]  left_x;
  logic [7:0]  left_y;
  logic [7:0]  right_x;
  logic [7:0]  right_y;

  modport source (output valid, output select_n, output serial_clock, output data_out,
                  output busy_res, output done_res, output link_mode, output keys_valid,
                  output buttons, output left_x, output left_y, output right_x,
                  output right_y, input ready);
  modport sink (input valid, input select_n, input serial_clock, input data_out,
                input busy_res, input done_res, input link_mode, input keys_valid,
                input buttons, input left_x, input left_y, input right_x,
                input right_y, output ready);
endinterface
`default_nettype wire

>>> rtl/gpsm_core.sv
// Transfer sequencer, reply byte store and decode of the poll master.
`timescale 1ns / 1ps
`default_nettype none
module gpsm_core #(
  parameter int FRAME_BYTES = 9
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             step,
  input  wire logic [1:0]       cmd,
  input  wire logic             data_in,
  input  wire gpsm_pkg::cfg_t   cfg,
  output gpsm_pkg::result_t     result
);
  import gpsm_pkg::*;

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_PRE  = 3'd1;
  localparam logic [2:0] PH_HIGH = 3'd2;
  localparam logic [2:0] PH_LOW  = 3'd3;
  localparam logic [2:0] PH_POST = 3'd4;

  localparam logic [4:0] SCAN_LEN  = 5'(FRAME_BYTES);
  localparam logic [4:0] LIGHT_LEN = 5'd2;

  logic [2:0]  phase, phase_next;
  logic [9:0]  tick_count, tick_count_next;
  logic [2:0]  bit_index, bit_index_next;
  logic [3:0]  byte_index, byte_index_next;
  logic        is_scan, is_scan_next;
  logic [7:0]  rx_shift, rx_shift_next;
  logic [1:0]  link_mode, link_mode_next;
  logic        keys_valid, keys_valid_next;
  logic [15:0] buttons, buttons_next;
  logic [7:0]  left_x, left_x_next, left_y, left_y_next;
  logic [7:0]  right_x, right_x_next, right_y, right_y_next;

  logic [7:0]  reply [2:8];
  logic [7:0]  reply_at [2:8];
  logic        store_we;

  logic [9:0]  h;
  logic [10:0] tick_inc;
  logic        expired;
  logic [7:0]  rx_new;
  logic [3:0]  byte_inc;
  logic [4:0]  frame_len;
  logic        done;

  assign h        = (cfg.half_period == 10'd0) ? 10'd1 : cfg.half_period;
  assign tick_inc = {1'b0, tick_count} + 11'd1;
  assign expired  = tick_inc >= {1'b0, h};
  assign byte_inc = byte_index + 4'd1;
  assign frame_len = is_scan ? SCAN_LEN : LIGHT_LEN;

  // Reply bytes beyond the frame read as zero.
  always_comb begin
    for (int k = 2; k <= 8; k++) begin
      reply_at[k] = (k < FRAME_BYTES) ? reply[k] : 8'h00;
    end
  end

  always_comb begin
    rx_new = rx_shift;
    if (tick_count == 10'd0) begin
      rx_new = rx_shift | (8'(data_in) << bit_index);
    end
  end

  always_comb begin
    phase_next      = phase;
    tick_count_next = tick_count;
    bit_index_next  = bit_index;
    byte_index_next = byte_index;
    is_scan_next    = is_scan;
    rx_shift_next   = rx_shift;
    link_mode_next  = link_mode;
    keys_valid_next = keys_valid;
    buttons_next    = buttons;
    left_x_next     = left_x;
    left_y_next     = left_y;
    right_x_next    = right_x;
    right_y_next    = right_y;
    store_we        = 1'b0;
    done            = 1'b0;
    unique case (phase)
      PH_IDLE: begin
        if (cmd == CMD_LIGHT || cmd == CMD_SCAN) begin
          is_scan_next    = (cmd == CMD_SCAN);
          bit_index_next  = 3'd0;
          byte_index_next = 4'd0;
          rx_shift_next   = 8'h00;
          tick_count_next = 10'd0;
          phase_next      = (cmd == CMD_SCAN) ? PH_PRE : PH_HIGH;
        end
      end
      PH_PRE, PH_HIGH, PH_POST: begin
        tick_count_next = expired ? 10'd0 : tick_inc[9:0];
        if (expired) begin
          if (phase == PH_PRE) begin
            phase_next = PH_HIGH;
          end else if (phase == PH_HIGH) begin
            phase_next = PH_LOW;
          end else begin
            phase_next = PH_IDLE;
            done       = 1'b1;
            if (reply_at[2] == MARK_KEYS) begin
              keys_valid_next = 1'b1;
              buttons_next    = {reply_at[4], reply_at[3]};
              right_x_next    = reply_at[5];
              right_y_next    = reply_at[6];
              left_x_next     = reply_at[7];
              left_y_next     = reply_at[8];
            end else begin
              keys_valid_next = 1'b0;
              buttons_next    = 16'h0000;
              right_x_next    = 8'h00;
              right_y_next    = 8'h00;
              left_x_next     = 8'h00;
              left_y_next     = 8'h00;
            end
          end
        end
      end
      PH_LOW: begin
        rx_shift_next   = rx_new;
        tick_count_next = expired ? 10'd0 : tick_inc[9:0];
        if (expired) begin
          if (bit_index == 3'd7) begin
            store_we        = 1'b1;
            rx_shift_next   = 8'h00;
            bit_index_next  = 3'd0;
            byte_index_next = byte_inc;
            if (byte_inc == 4'd0 || {1'b0, byte_inc} >= frame_len) begin
              if (is_scan) begin
                phase_next = PH_POST;
              end else begin
                // The id byte is the one completing on this tick.
                phase_next = PH_IDLE;
                done       = 1'b1;
                if (rx_new == cfg.red_mode_id) begin
                  link_mode_next = MODE_RED;
                end else if (rx_new == cfg.green_mode_id) begin
                  link_mode_next = MODE_GREEN;
                end else begin
                  link_mode_next = MODE_NONE;
                end
              end
            end else begin
              phase_next = PH_HIGH;
            end
          end else begin
            bit_index_next = bit_index + 3'd1;
            phase_next     = PH_HIGH;
          end
        end
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase
  end

  always_comb begin
    logic bitph;
    logic [7:0] tx;
    bitph = (phase_next == PH_HIGH) || (phase_next == PH_LOW);
    tx    = tx_byte(byte_index_next);
    result.select_n     = (phase_next == PH_IDLE) || (phase_next == PH_POST);
    result.serial_clock = (phase_next != PH_LOW);
    result.data_out     = bitph & tx[bit_index_next];
    result.busy_res     = (phase_next != PH_IDLE);
    result.done_res     = done;
    result.link_mode    = link_mode_next;
    result.keys_valid   = keys_valid_next;
    result.buttons      = buttons_next;
    result.left_x       = left_x_next;
    result.left_y       = left_y_next;
    result.right_x      = right_x_next;
    result.right_y      = right_y_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      tick_count <= 10'd0;
      bit_index  <= 3'd0;
      byte_index <= 4'd0;
      is_scan    <= 1'b0;
      rx_shift   <= 8'h00;
      link_mode  <= MODE_NONE;
      keys_valid <= 1'b0;
      buttons    <= 16'h0000;
      left_x     <= 8'h00;
      left_y     <= 8'h00;
      right_x    <= 8'h00;
      right_y    <= 8'h00;
    end else if (step) begin
      phase      <= phase_next;
      tick_count <= tick_count_next;
      bit_index  <= bit_index_next;
      byte_index <= byte_index_next;
      is_scan    <= is_scan_next;
      rx_shift   <= rx_shift_next;
      link_mode  <= link_mode_next;
      keys_valid <= keys_valid_next;
      buttons    <= buttons_next;
      left_x     <= left_x_next;
      left_y     <= left_y_next;
      right_x    <= right_x_next;
      right_y    <= right_y_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 2; k <= 8; k++) begin
      if (step && store_we && byte_index == 4'(k)) begin
        reply[k] <= rx_new;
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/gamepad_poll_serial_master_top.sv
// Top level of the gamepad poll master: config registers, handshake and output word.
// The word for a tick is registered and appears in the cycle after the tick is accepted.
// Throughput: one tick per cycle; a tick enters when the output register is empty or drains.
// A light read takes 1 + 32 * half_period ticks, a scan 1 + (16 * FRAME_BYTES + 2) *
// half_period ticks, with a zero half period counting as one.
// Reset idles the link, zeroes the held results and loads the register defaults.
`timescale 1ns / 1ps
`default_nettype none
module gamepad_poll_serial_master_top #(
  parameter int FRAME_BYTES = 9
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  gpsm_in_if.sink                                in_ch,
  gpsm_out_if.source                             out_ch,
  input  wire logic                              cfg_we,
  input  wire logic [1:0]                        cfg_index,
  input  wire logic [gpsm_pkg::CFG_WIDTH-1:0]    cfg_data
);
  import gpsm_pkg::*;

  cfg_t    cfg;
  result_t result;
  result_t word;
  logic    out_valid;
  logic    accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.half_period   <= 10'd8;
      cfg.red_mode_id   <= 8'd115;
      cfg.green_mode_id <= 8'd65;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_HALF_PERIOD: cfg.half_period   <= cfg_data;
        REG_RED_ID:      cfg.red_mode_id   <= cfg_data[7:0];
        REG_GREEN_ID:    cfg.green_mode_id <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  assign in_ch.ready = !out_valid || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  gpsm_core #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_core (
    .clk(clk),
    .rst(rst),
    .step(accept),
    .cmd(in_ch.cmd),
    .data_in(in_ch.data_in),
    .cfg(cfg),
    .result(result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      word <= result;
    end
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.select_n     = word.select_n;
  assign out_ch.serial_clock = word.serial_clock;
  assign out_ch.data_out     = word.data_out;
  assign out_ch.busy_res     = word.busy_res;
  assign out_ch.done_res     = word.done_res;
  assign out_ch.link_mode    = word.link_mode;
  assign out_ch.keys_valid   = word.keys_valid;
  assign out_ch.buttons      = word.buttons;
  assign out_ch.left_x       = word.left_x;
  assign out_ch.left_y       = word.left_y;
  assign out_ch.right_x      = word.right_x;
  assign out_ch.right_y      = word.right_y;

  // A finished transfer has already left the busy state.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && word.done_res |-> !word.busy_res)
    else $error("done word still shows busy");

  // The serial clock only goes low inside a selected transfer.
  a_clock_selected: assert property (@(posedge clk) disable iff (rst)
    out_valid && !word.serial_clock |-> !word.select_n && word.busy_res)
    else $error("serial clock low outside a transfer");

  // Every accepted tick yields a word in the next cycle.
  a_word_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted tick produced no word");

endmodule
`default_nettype wire

>>> sim/tb_top.sv
// Testbench for the gamepad poll master: drives link ticks and checks each output word.
`timescale 1ns / 1ps
module tb_top;
  import gpsm_pkg::*;

  localparam int FRAME_LEN = 9;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int FILL_RANDOM = 0;
  localparam int FILL_ZERO = 1;
  localparam int FILL_ONES = 2;
  localparam int LONG_HOLD = 150;

  typedef enum logic [2:0] {
    LINK_IDLE,
    LINK_SETTLE,
    LINK_HIGH,
    LINK_LOW,
    LINK_RELEASE
  } link_phase_t;

  class gamepad_line_predictor;
    cfg_t regs;
    link_phase_t phase;
    logic [9:0] ticks;
    logic [2:0] bit_idx;
    logic [3:0] byte_idx;
    logic scan_mode;
    logic [7:0] rx_byte;
    logic [7:0] replies [16];
    result_t held;
    result_t expected_lines [$];
    int mismatches;

    function new();
      regs.half_period = 10'd8;
      regs.red_mode_id = 8'd115;
      regs.green_mode_id = 8'd65;
      phase = LINK_IDLE;
      ticks = '0;
      bit_idx = '0;
      byte_idx = '0;
      scan_mode = 1'b0;
      rx_byte = '0;
      foreach (replies[i]) replies[i] = '0;
      held = '0;
      mismatches = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [CFG_WIDTH-1:0] data);
      case (idx)
        REG_HALF_PERIOD: regs.half_period = data;
        REG_RED_ID: regs.red_mode_id = data[7:0];
        REG_GREEN_ID: regs.green_mode_id = data[7:0];
        default: ;
      endcase
    endfunction

    function logic [7:0] reply_at(int idx);
      return (idx >= FRAME_LEN) ? 8'h00 : replies[idx];
    endfunction

    function void note_tick(logic [1:0] cmd, logic din);
      result_t w;
      int h;
      int frame;
      logic done;
      logic expired;
      logic [7:0] tx;
      h = (regs.half_period == 10'd0) ? 1 : int'(regs.half_period);
      done = 1'b0;
      if (phase == LINK_IDLE) begin
        if (cmd == CMD_LIGHT || cmd == CMD_SCAN) begin
          scan_mode = (cmd == CMD_SCAN);
          bit_idx = '0;
          byte_idx = '0;
          rx_byte = '0;
          ticks = '0;
          phase = scan_mode ? LINK_SETTLE : LINK_HIGH;
        end
      end else begin
        if (phase == LINK_LOW && ticks == 10'd0) begin
          rx_byte = rx_byte | (8'(din) << bit_idx);
        end
        expired = (int'(ticks) + 1 >= h);
        ticks = expired ? 10'd0 : ticks + 10'd1;
        if (expired) begin
          case (phase)
            LINK_SETTLE: phase = LINK_HIGH;
            LINK_HIGH: phase = LINK_LOW;
            LINK_RELEASE: begin
              if (reply_at(2) == MARK_KEYS) begin
                held.keys_valid = 1'b1;
                held.buttons = {reply_at(4), reply_at(3)};
                held.right_x = reply_at(5);
                held.right_y = reply_at(6);
                held.left_x = reply_at(7);
                held.left_y = reply_at(8);
              end else begin
                held.keys_valid = 1'b0;
                held.buttons = '0;
                held.right_x = '0;
                held.right_y = '0;
                held.left_x = '0;
                held.left_y = '0;
              end
              phase = LINK_IDLE;
              done = 1'b1;
            end
            default: begin
              if (bit_idx == 3'd7) begin
                frame = scan_mode ? FRAME_LEN : 2;
                replies[byte_idx] = rx_byte;
                rx_byte = '0;
                bit_idx = '0;
                byte_idx = byte_idx + 4'd1;
                if (byte_idx == 4'd0 || int'(byte_idx) >= frame) begin
                  if (scan_mode) begin
                    phase = LINK_RELEASE;
                  end else begin
                    if (replies[1] == regs.red_mode_id) begin
                      held.link_mode = MODE_RED;
                    end else if (replies[1] == regs.green_mode_id) begin
                      held.link_mode = MODE_GREEN;
                    end else begin
                      held.link_mode = MODE_NONE;
                    end
                    phase = LINK_IDLE;
                    done = 1'b1;
                  end
                end else begin
                  phase = LINK_HIGH;
                end
              end else begin
                bit_idx = bit_idx + 3'd1;
                phase = LINK_HIGH;
              end
            end
          endcase
        end
      end

      if (byte_idx == 4'd0) begin
        tx = BYTE_START;
      end else if (byte_idx == 4'd1) begin
        tx = BYTE_POLL;
      end else begin
        tx = 8'h00;
      end
      w = held;
      w.select_n = (phase == LINK_IDLE || phase == LINK_RELEASE);
      w.serial_clock = (phase != LINK_LOW);
      w.data_out = (phase == LINK_HIGH || phase == LINK_LOW) ? tx[bit_idx] : 1'b0;
      w.busy_res = (phase != LINK_IDLE);
      w.done_res = done;
      expected_lines.push_back(w);
    endfunction

    function void compare_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
      if (act_v !== exp_v) begin
        $error("%s: expected %0h, got %0h", name, exp_v, act_v);
        mismatches++;
      end
    endfunction

    function void check_word(result_t act);
      result_t e;
      if (expected_lines.size() == 0) begin
        $error("output word with nothing expected");
        mismatches++;
        return;
      end
      e = expected_lines.pop_front();
      compare_field("select_n", 16'(e.select_n), 16'(act.select_n));
      compare_field("serial_clock", 16'(e.serial_clock), 16'(act.serial_clock));
      compare_field("data_out", 16'(e.data_out), 16'(act.data_out));
      compare_field("busy_res", 16'(e.busy_res), 16'(act.busy_res));
      compare_field("done_res", 16'(e.done_res), 16'(act.done_res));
      compare_field("link_mode", 16'(e.link_mode), 16'(act.link_mode));
      compare_field("keys_valid", 16'(e.keys_valid), 16'(act.keys_valid));
      compare_field("buttons", e.buttons, act.buttons);
      compare_field("left_x", 16'(e.left_x), 16'(act.left_x));
      compare_field("left_y", 16'(e.left_y), 16'(act.left_y));
      compare_field("right_x", 16'(e.right_x), 16'(act.right_x));
      compare_field("right_y", 16'(e.right_y), 16'(act.right_y));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [CFG_WIDTH-1:0] cfg_data;

  gpsm_in_if in_ch();
  gpsm_out_if out_ch();

  gamepad_poll_serial_master_top #(
    .FRAME_BYTES(FRAME_LEN)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  gamepad_line_predictor line_pred = new();
  int src_idle_pct = 0;
  int snk_idle_pct = 0;
  int flip_pct = 0;
  bit hold_request = 1'b0;
  int ticks_sent = 0;
  logic [7:0] reply_plan [16];

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int idle_gap(int pct);
    int r;
    if ($urandom_range(99) >= pct) return 0;
    r = $urandom_range(99);
    if (r < 80) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 8);
    return $urandom_range(10, 24);
  endfunction

  // The sampled data level follows the planned reply on the first low tick of each bit.
  function automatic logic line_level();
    logic b;
    if (line_pred.phase == LINK_LOW && line_pred.ticks == 10'd0) begin
      b = reply_plan[line_pred.byte_idx][line_pred.bit_idx];
      if ($urandom_range(99) < flip_pct) b = ~b;
      return b;
    end
    return 1'($urandom_range(1));
  endfunction

  function automatic logic [7:0] fill_byte(int fill);
    int r;
    if (fill == FILL_ZERO) return 8'h00;
    if (fill == FILL_ONES) return 8'hFF;
    r = $urandom_range(99);
    if (r < 10) return 8'h00;
    if (r < 20) return 8'hFF;
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [1:0] stray_cmd();
    case ($urandom_range(3))
      0: return CMD_LIGHT;
      1: return CMD_SCAN;
      2: return CMD_UNUSED;
      default: return CMD_TICK;
    endcase
  endfunction

  task automatic plan_reply(input logic [7:0] key_byte, input int key_pos, input int fill);
    foreach (reply_plan[i]) reply_plan[i] = fill_byte(fill);
    reply_plan[key_pos] = key_byte;
  endtask

  task automatic send_tick(input logic [1:0] cmd, input logic din);
    int gap;
    gap = idle_gap(src_idle_pct);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.cmd <= cmd;
    in_ch.data_in <= din;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    line_pred.note_tick(cmd, din);
    ticks_sent++;
  endtask

  task automatic idle_ticks(input int n);
    repeat (n) send_tick(($urandom_range(1) == 0) ? CMD_TICK : CMD_UNUSED, 1'($urandom_range(1)));
  endtask

  task automatic run_transfer(input logic [1:0] start_cmd, input int busy_cmd_pct);
    logic [1:0] c;
    send_tick(start_cmd, 1'($urandom_range(1)));
    while (line_pred.phase != LINK_IDLE) begin
      c = ($urandom_range(99) < busy_cmd_pct) ? stray_cmd() : CMD_TICK;
      send_tick(c, line_level());
    end
  endtask

  task automatic drain_lines();
    in_ch.valid <= 1'b0;
    while (line_pred.expected_lines.size() > 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic set_registers(input logic [9:0] half, input logic [7:0] red,
                               input logic [7:0] green);
    logic [CFG_WIDTH-1:0] vals [3];
    vals[0] = half;
    vals[1] = CFG_WIDTH'(red);
    vals[2] = CFG_WIDTH'(green);
    drain_lines();
    for (int i = 0; i < 3; i++) begin
      @(posedge clk);
      cfg_we <= 1'b1;
      cfg_index <= 2'(i);
      cfg_data <= vals[i];
    end
    @(posedge clk);
    cfg_we <= 1'b0;
    for (int i = 0; i < 3; i++) line_pred.write_reg(2'(i), vals[i]);
  endtask

  always @(posedge clk) begin
    result_t act;
    if (!rst && out_ch.valid && out_ch.ready) begin
      act.select_n = out_ch.select_n;
      act.serial_clock = out_ch.serial_clock;
      act.data_out = out_ch.data_out;
      act.busy_res = out_ch.busy_res;
      act.done_res = out_ch.done_res;
      act.link_mode = out_ch.link_mode;
      act.keys_valid = out_ch.keys_valid;
      act.buttons = out_ch.buttons;
      act.left_x = out_ch.left_x;
      act.left_y = out_ch.left_y;
      act.right_x = out_ch.right_x;
      act.right_y = out_ch.right_y;
      line_pred.check_word(act);
    end
  end

  initial begin
    int gap;
    forever begin
      gap = idle_gap(snk_idle_pct);
      if (hold_request) begin
        hold_request = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin
    #8000000;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    logic [9:0] half;
    logic [7:0] red;
    logic [7:0] green;
    int r;
    int n_transfers;

    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= REG_HALF_PERIOD;
    cfg_data <= '0;
    in_ch.valid <= 1'b0;
    in_ch.cmd <= CMD_TICK;
    in_ch.data_in <= 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Reset defaults: a light read that reports the red mode.
    idle_ticks(4);
    plan_reply(8'd115, 1, FILL_RANDOM);
    run_transfer(CMD_LIGHT, 0);

    set_registers(10'd1, 8'h00, 8'hFF);
    plan_reply(8'hFF, 1, FILL_RANDOM);
    run_transfer(CMD_LIGHT, 0);
    plan_reply(8'h00, 1, FILL_ONES);
    run_transfer(CMD_LIGHT, 0);
    plan_reply(8'h33, 1, FILL_RANDOM);
    run_transfer(CMD_LIGHT, 0);
    plan_reply(MARK_KEYS, 2, FILL_ZERO);
    run_transfer(CMD_SCAN, 0);
    plan_reply(MARK_KEYS, 2, FILL_ONES);
    run_transfer(CMD_SCAN, 0);
    plan_reply(8'hA5, 2, FILL_ONES);
    run_transfer(CMD_SCAN, 100);

    // Long stall on the result side while the scan keeps offering words.
    plan_reply(MARK_KEYS, 2, FILL_RANDOM);
    hold_request = 1'b1;
    run_transfer(CMD_SCAN, 50);
    drain_lines();

    // A zero half period behaves as one tick.
    set_registers(10'd0, 8'hFF, 8'h00);
    plan_reply(8'hFF, 1, FILL_ZERO);
    run_transfer(CMD_LIGHT, 30);
    plan_reply(MARK_KEYS, 2, FILL_RANDOM);
    run_transfer(CMD_SCAN, 30);

    // With equal ids the red mode takes precedence.
    set_registers(10'd1, MARK_KEYS, MARK_KEYS);
    plan_reply(MARK_KEYS, 1, FILL_RANDOM);
    run_transfer(CMD_LIGHT, 30);
    idle_ticks(3);

    n_transfers = 0;
    while (ticks_sent < 1400) begin
      if (n_transfers % 8 == 0) begin
        r = $urandom_range(99);
        if (r < 55) half = 10'd1;
        else if (r < 80) half = 10'd2;
        else if (r < 90) half = 10'd3;
        else if (r < 95) half = 10'd0;
        else half = 10'($urandom_range(4, 12));
        red = 8'($urandom_range(255));
        green = ($urandom_range(99) < 20) ? red : 8'($urandom_range(255));
        set_registers(half, red, green);
        src_idle_pct = ($urandom_range(3) == 0) ? 0 : 30;
        snk_idle_pct = ($urandom_range(3) == 0) ? 0 : 30;
      end
      idle_ticks($urandom_range(0, 3));
      flip_pct = ($urandom_range(99) < 15) ? 5 : 0;
      if ($urandom_range(1) == 1) begin
        plan_reply(($urandom_range(99) < 80) ? MARK_KEYS : 8'($urandom_range(255)), 2,
                   FILL_RANDOM);
        run_transfer(CMD_SCAN, 20);
      end else begin
        r = $urandom_range(99);
        plan_reply((r < 40) ? line_pred.regs.red_mode_id :
                   (r < 75) ? line_pred.regs.green_mode_id : 8'($urandom_range(255)), 1,
                   FILL_RANDOM);
        run_transfer(CMD_LIGHT, 20);
      end
      n_transfers++;
    end

    drain_lines();
    repeat (5) @(posedge clk);
    if (line_pred.mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule
